### rtl/ixg_pkg.sv
// Shared types, constants and step functions of the interleaved xoshiro256++ generator.
`default_nettype none

package ixg_pkg;

  // Lane count limits and field widths
  localparam int unsigned IXG_MAX_LANES = 8;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned CFG_W         = 4;
  localparam int unsigned LANE_W        = 3;
  localparam int unsigned WORD_W        = 64;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;

  // Operation codes
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // xoshiro256++ rotation and shift amounts
  localparam int unsigned ROT_SUM   = 23;
  localparam int unsigned SHIFT_T   = 17;
  localparam int unsigned ROT_S3    = 45;
  localparam int unsigned DROP_BITS = 12;

  // Double format
  localparam int unsigned FRAC_W = 52;
  localparam int unsigned EXP_W  = 11;
  localparam logic [EXP_W-1:0] EXP_HALF = 11'd1022;  // exponent of [0.5, 1)
  localparam int unsigned NORM_W = WORD_W - DROP_BITS + 1;  // 53-bit odd value

  typedef struct packed {
    logic [WORD_W-1:0] s0;
    logic [WORD_W-1:0] s1;
    logic [WORD_W-1:0] s2;
    logic [WORD_W-1:0] s3;
  } ixg_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] raw;
    logic [LANE_W-1:0] lane;
  } ixg_draw_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned k);
    rotl = (v << k) | (v >> (WORD_W - k));
  endfunction

  // Output word of one step
  function automatic logic [WORD_W-1:0] xs_out(input ixg_state_t s);
    xs_out = rotl(s.s0 + s.s3, ROT_SUM) + s.s0;
  endfunction

  // State after one step
  function automatic ixg_state_t xs_next(input ixg_state_t s);
    ixg_state_t        n;
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] a2;
    logic [WORD_W-1:0] a3;
    t    = s.s1 << SHIFT_T;
    a2   = s.s2 ^ s.s0;
    a3   = s.s3 ^ s.s1;
    n.s1 = s.s1 ^ a2;
    n.s0 = s.s0 ^ a3;
    n.s2 = a2 ^ t;
    n.s3 = rotl(a3, ROT_S3);
    xs_next = n;
  endfunction

endpackage

`default_nettype wire

### rtl/ixg_if.sv
// Request and response channel interfaces of the interleaved xoshiro256++ generator.
`default_nettype none

interface ixg_req_if;
  import ixg_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [LANE_W-1:0] lane;
  logic [WORD_W-1:0] seed_word0;
  logic [WORD_W-1:0] seed_word1;
  logic [WORD_W-1:0] seed_word2;
  logic [WORD_W-1:0] seed_word3;

  modport source (output valid, op, lane, seed_word0, seed_word1, seed_word2, seed_word3,
                  input ready);
  modport sink (input valid, op, lane, seed_word0, seed_word1, seed_word2, seed_word3,
                output ready);
endinterface

interface ixg_rsp_if;
  import ixg_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] raw_word;
  logic [WORD_W-1:0] unit_double;
  logic [LANE_W-1:0] source_lane;

  modport source (output valid, raw_word, unit_double, source_lane, input ready);
  modport sink (input valid, raw_word, unit_double, source_lane, output ready);
endinterface

`default_nettype wire

### rtl/ixg_double_pipe.sv
// Two-stage conversion of a raw word to the unit double, ending in the output register.
`default_nettype none

module ixg_double_pipe (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output                     logic in_ready_o,
  input  wire  ixg_pkg::ixg_draw_t in_draw_i,
  ixg_rsp_if.source                rsp_o
);
  import ixg_pkg::*;

  // Stage 2: leading-zero count
  logic                        v2_q;
  ixg_draw_t                   d2_q;
  logic [$clog2(NORM_W)-1:0]   lz2_q;
  logic [$clog2(NORM_W)-1:0]   lz_d;
  logic [NORM_W-1:0]           norm_in;

  // Stage 3: output register
  logic              v3_q;
  ixg_draw_t         d3_q;
  logic [WORD_W-1:0] dbl3_q;
  logic [WORD_W-1:0] dbl_d;
  logic [NORM_W-1:0] norm2;
  logic [NORM_W-1:0] shifted;

  logic adv2;
  logic adv3;

  assign adv3       = !v3_q || rsp_o.ready;
  assign adv2       = !v2_q || adv3;
  assign in_ready_o = adv2;

  // Find the top one of the odd value 2m+1
  always_comb begin
    norm_in = {in_draw_i.raw[WORD_W-1:DROP_BITS], 1'b1};
    lz_d    = '0;
    for (int i = 0; i < NORM_W; i++) begin
      if (norm_in[i]) begin
        lz_d = ($clog2(NORM_W))'(NORM_W - 1 - i);
      end
    end
  end

  // Normalize and assemble the double
  always_comb begin
    norm2   = {d2_q.raw[WORD_W-1:DROP_BITS], 1'b1};
    shifted = norm2 << lz2_q;
    dbl_d   = {1'b0, EXP_HALF - EXP_W'(lz2_q), shifted[FRAC_W-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv2) v2_q <= in_valid_i;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Payload: load on advance
  always_ff @(posedge clk_i) begin
    if (adv2 && in_valid_i) begin
      d2_q  <= in_draw_i;
      lz2_q <= lz_d;
    end
    if (adv3 && v2_q) begin
      d3_q   <= d2_q;
      dbl3_q <= dbl_d;
    end
  end

  assign rsp_o.valid       = v3_q;
  assign rsp_o.raw_word    = d3_q.raw;
  assign rsp_o.unit_double = dbl3_q;
  assign rsp_o.source_lane = d3_q.lane;

endmodule

`default_nettype wire

### rtl/interleaved_xoshiro256pp_generator.sv
// Top level of the interleaved multi-lane xoshiro256++ generator.
// Each lane keeps its four 64-bit state words in flip-flops. A seed transaction writes one
// lane (an all-zero seed becomes word0 = 1) and resets the lane pointer; a draw transaction
// steps the lane under the pointer in the cycle it is accepted and moves the pointer
// round-robin over the lanes in use. One transaction is accepted every clock cycle while
// the response side keeps taking results; the read-step-write loop on the lane state sets
// that rate. An accepted draw reaches the response channel through the raw-word register,
// the leading-zero count stage and then the output register that carries raw_word,
// unit_double and source_lane. Seeds give no response. lanes_in_use is written through
// cfg_we_i / cfg_wdata_i; 0 counts as 1 and values above MAX_LANES as MAX_LANES. Drawing
// from a lane never seeded returns unspecified values.
`default_nettype none

module interleaved_xoshiro256pp_generator #(
  parameter int unsigned MAX_LANES = ixg_pkg::IXG_MAX_LANES
) (
  input  wire  logic                     clk_i,
  input  wire  logic                     rst_ni,
  input  wire  logic                     cfg_we_i,
  input  wire  logic [ixg_pkg::CFG_W-1:0] cfg_wdata_i,
  ixg_req_if.sink                        req_i,
  ixg_rsp_if.source                      rsp_o
);
  import ixg_pkg::*;

  localparam int unsigned LaneIdxW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;

  // Configuration register
  logic [CFG_W-1:0] cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Clamp the lane count
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cfg_ext;

  assign cfg_ext = CNT_W'(cfg_q);

  always_comb begin
    priority if (cfg_ext == '0) begin
      cnt = CNT_W'(1);
    end else if (cfg_ext > CNT_W'(MAX_LANES)) begin
      cnt = CNT_W'(MAX_LANES);
    end else begin
      cnt = cfg_ext;
    end
  end

  // Lane state and pointer
  ixg_state_t          lane_q [MAX_LANES];
  logic [LaneIdxW-1:0] ptr_q;
  logic [LaneIdxW-1:0] ptr_d;
  logic [LaneIdxW-1:0] cur;
  logic [CNT_W-1:0]    cur_inc;

  // Stage 1 register
  logic      v1_q;
  ixg_draw_t d1_q;
  logic      pipe_ready;
  logic      adv1;

  logic       accept;
  logic       seed_ok;
  logic       is_draw;
  logic       is_seed;
  ixg_state_t cur_st;
  ixg_state_t seed_st;
  logic [LaneIdxW-1:0] seed_idx;

  assign adv1        = !v1_q || pipe_ready;
  assign req_i.ready = adv1;
  assign accept      = req_i.valid && adv1;
  assign is_draw     = accept && (req_i.op == OP_DRAW);
  assign is_seed     = accept && (req_i.op == OP_SEED);
  assign seed_ok     = CNT_W'(req_i.lane) < CNT_W'(MAX_LANES);
  assign seed_idx    = LaneIdxW'(req_i.lane);

  // Select the lane to step
  always_comb begin
    cur = (CNT_W'(ptr_q) >= cnt) ? '0 : ptr_q;
    cur_inc = CNT_W'(cur) + CNT_W'(1);
    ptr_d = (cur_inc >= cnt) ? '0 : LaneIdxW'(cur_inc);
    cur_st = lane_q[cur];
  end

  // Form the seed, replacing an all-zero one
  always_comb begin
    seed_st.s0 = req_i.seed_word0;
    seed_st.s1 = req_i.seed_word1;
    seed_st.s2 = req_i.seed_word2;
    seed_st.s3 = req_i.seed_word3;
    if ((req_i.seed_word0 | req_i.seed_word1 | req_i.seed_word2 | req_i.seed_word3) == '0) begin
      seed_st.s0 = WORD_W'(1);
    end
  end

  // Advance the pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      if (is_seed && seed_ok) begin
        ptr_q <= '0;
      end else if (is_draw) begin
        ptr_q <= ptr_d;
      end
      if (adv1) v1_q <= is_draw;
    end
  end

  // Write back the lane state and hold the raw word
  always_ff @(posedge clk_i) begin
    if (is_seed && seed_ok) begin
      lane_q[seed_idx] <= seed_st;
    end else if (is_draw) begin
      lane_q[cur] <= xs_next(cur_st);
    end
    if (is_draw) begin
      d1_q.raw  <= xs_out(cur_st);
      d1_q.lane <= LANE_W'(cur);
    end
  end

  ixg_double_pipe u_double_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v1_q),
    .in_ready_o (pipe_ready),
    .in_draw_i  (d1_q),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

### verif/ixg_draw_checker.sv
// Watches the generator channels, predicts every draw and compares the results.
`timescale 1ns / 100ps

module ixg_draw_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ixg_pkg::CFG_W-1:0] cfg_wdata_i,
  ixg_req_if                        req_mon,
  ixg_rsp_if                        rsp_mon,
  output int                        mismatch_count,
  output int                        pending_draws
);
  import ixg_pkg::*;

  localparam int unsigned PRINT_CAP = 40;

  typedef struct packed {
    logic [WORD_W-1:0] raw_word;
    logic [WORD_W-1:0] unit_double;
    logic [LANE_W-1:0] source_lane;
  } draw_expect_t;

  ixg_state_t        lane_state [IXG_MAX_LANES];
  logic [LANE_W-1:0] draw_ptr;
  logic [CFG_W-1:0]  lanes_reg;
  draw_expect_t      expected_draws [$];
  draw_expect_t      want;
  draw_expect_t      fresh;
  int unsigned       served;
  int unsigned       pick;
  ixg_state_t        seed;

  // Rotate left through a doubled word
  function automatic logic [WORD_W-1:0] spin_left(input logic [WORD_W-1:0] v,
                                                  input int unsigned k);
    logic [2*WORD_W-1:0] both;
    both = {v, v} << k;
    return both[2*WORD_W-1:WORD_W];
  endfunction

  // Output word of a lane before its step
  function automatic logic [WORD_W-1:0] scramble(input ixg_state_t s);
    return spin_left(s.s0 + s.s3, 23) + s.s0;
  endfunction

  // Lane state after one step
  function automatic ixg_state_t advance(input ixg_state_t s);
    ixg_state_t        r;
    logic [WORD_W-1:0] mix2;
    logic [WORD_W-1:0] mix3;
    mix2 = s.s2 ^ s.s0;
    mix3 = s.s3 ^ s.s1;
    r.s0 = s.s0 ^ mix3;
    r.s1 = s.s1 ^ mix2;
    r.s2 = mix2 ^ (s.s1 << 17);
    r.s3 = spin_left(mix3, 45);
    return r;
  endfunction

  // Double bits of (2*(raw >> 12) + 1) * 2^-53, normalized on the leading one
  function automatic logic [WORD_W-1:0] unit_bits(input logic [WORD_W-1:0] raw);
    logic [NORM_W-1:0] odd;
    int unsigned       msb;
    odd = {raw[WORD_W-1:DROP_BITS], 1'b1};
    msb = 0;
    for (int i = 0; i < NORM_W; i++) begin
      if (odd[i]) msb = i;
    end
    return {1'b0, EXP_W'(1023 + msb - 53), FRAC_W'(odd << (FRAC_W - msb))};
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_ptr = '0;
      lanes_reg = CFG_RESET;
      expected_draws.delete();
      mismatch_count = 0;
      pending_draws <= 0;
    end else begin
      // Track the lane count register
      if (cfg_we_i) lanes_reg = cfg_wdata_i;

      // Compare the result transaction with the oldest prediction
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_draws.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, raw %h", rsp_mon.raw_word));
        end else begin
          want = expected_draws.pop_front();
          if (rsp_mon.raw_word !== want.raw_word)
            report_mismatch($sformatf("raw_word %h, expected %h",
                                      rsp_mon.raw_word, want.raw_word));
          if (rsp_mon.unit_double !== want.unit_double)
            report_mismatch($sformatf("unit_double %h, expected %h",
                                      rsp_mon.unit_double, want.unit_double));
          if (rsp_mon.source_lane !== want.source_lane)
            report_mismatch($sformatf("source_lane %0d, expected %0d",
                                      rsp_mon.source_lane, want.source_lane));
        end
      end

      // Apply the request transaction to the predicted lanes
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.op == OP_SEED) begin
          seed = {req_mon.seed_word0, req_mon.seed_word1,
                  req_mon.seed_word2, req_mon.seed_word3};
          if (seed == '0) seed.s0 = 64'd1;
          lane_state[req_mon.lane] = seed;
          draw_ptr = '0;
        end else begin
          served = (lanes_reg == 0) ? 1 :
                   (lanes_reg > IXG_MAX_LANES) ? IXG_MAX_LANES : lanes_reg;
          pick = (draw_ptr >= served) ? 0 : draw_ptr;
          fresh.raw_word = scramble(lane_state[pick]);
          fresh.unit_double = unit_bits(fresh.raw_word);
          fresh.source_lane = LANE_W'(pick);
          lane_state[pick] = advance(lane_state[pick]);
          draw_ptr = (pick + 1 >= served) ? '0 : LANE_W'(pick + 1);
          expected_draws.push_back(fresh);
        end
      end

      pending_draws <= expected_draws.size();
    end
  end

endmodule

### verif/interleaved_xoshiro256pp_generator_test.sv
// Stimulus, clock, reset and verdict for the interleaved xoshiro256++ generator.
`timescale 1ns / 100ps

module interleaved_xoshiro256pp_generator_test;
  import ixg_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_COUNT    = 12;
  localparam int unsigned PHASE_ITEMS    = 160;
  localparam int unsigned STEADY_PHASE   = 5;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             steady_run;
  int               mismatch_count;
  int               pending_draws;
  int unsigned      quiet_cycles = 0;

  ixg_req_if req_ch ();
  ixg_rsp_if rsp_ch ();

  interleaved_xoshiro256pp_generator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  ixg_draw_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_mon        (req_ch),
    .rsp_mon        (rsp_ch),
    .mismatch_count (mismatch_count),
    .pending_draws  (pending_draws)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side at random unless in the steady stretch
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= steady_run || ($urandom_range(0, 99) >= 24);
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly full random words, now and then all zeros or all ones
  function automatic logic [WORD_W-1:0] seed_word();
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return '0;
    if (roll == 1) return ALL_ONES;
    return {$urandom(), $urandom()};
  endfunction

  // Present one request transaction and hold it until accepted
  task automatic send_request(input logic op, input logic [LANE_W-1:0] lane,
                              input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                              input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3);
    while (!steady_run && $urandom_range(0, 99) < 24) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.lane <= lane;
    req_ch.seed_word0 <= w0;
    req_ch.seed_word1 <= w1;
    req_ch.seed_word2 <= w2;
    req_ch.seed_word3 <= w3;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // Draw with random filler in the ignored fields
  task automatic draw_one();
    send_request(OP_DRAW, LANE_W'($urandom_range(0, 7)), seed_word(), seed_word(),
                 seed_word(), seed_word());
  endtask

  // Drop valid and wait until every predicted draw has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_draws != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_lanes(input logic [CFG_W-1:0] lanes);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= lanes;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] phase_lanes [PHASE_COUNT];
    phase_lanes = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd2, 4'd6, 4'd5, 4'd7,
                    4'd4, 4'd9};
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    steady_run <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.op <= OP_SEED;
    req_ch.lane <= '0;
    req_ch.seed_word0 <= '0;
    req_ch.seed_word1 <= '0;
    req_ch.seed_word2 <= '0;
    req_ch.seed_word3 <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Seed every lane: smallest raw word, largest raw word, all-zero seed, all ones
    send_request(OP_SEED, 3'd0, '0, 64'd1, '0, '0);
    send_request(OP_SEED, 3'd1, ALL_ONES, '0, '0, 64'd1);
    send_request(OP_SEED, 3'd2, '0, '0, '0, '0);
    send_request(OP_SEED, 3'd3, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    for (int l = 4; l < IXG_MAX_LANES; l++) begin
      send_request(OP_SEED, LANE_W'(l), seed_word(), seed_word(), seed_word(), seed_word());
    end

    // Six draws, one and a half rounds over the reset lane count of four, then a seed mid-round rewinds the pointer
    repeat (6) draw_one();
    send_request(OP_SEED, 3'd5, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                 {$urandom(), $urandom()}, {$urandom(), $urandom()});
    draw_one();

    // Random phases over a sweep of lane counts, two of them random
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p >= PHASE_COUNT - 2) phase_lanes[p] = CFG_W'($urandom_range(0, 15));
      set_lanes(phase_lanes[p]);
      steady_run <= (p == STEADY_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 12) begin
          if ($urandom_range(0, 9) == 0)
            send_request(OP_SEED, LANE_W'($urandom_range(0, 7)), '0, '0, '0, '0);
          else
            send_request(OP_SEED, LANE_W'($urandom_range(0, 7)), seed_word(), seed_word(),
                         seed_word(), seed_word());
        end else begin
          draw_one();
        end
      end
    end

    drain();
    if (mismatch_count == 0 && pending_draws == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
